FILE: rtl/assert_macros.svh
// Assertion macros used by the checker of the FIR filter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/fir32_pkg.sv
// Package with the sizes, codes and controller types of the 32-tap FIR filter.
`timescale 1ns / 1ps

package fir32_pkg;

    localparam int TAPS         = 32;
    localparam int SAMPLE_WIDTH = 16;
    localparam int TAP_W        = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int INDEX_W      = 5;
    localparam int VALUE_W      = 16;
    localparam int SUM_W        = 40;
    localparam int PROD_W       = 2 * SAMPLE_WIDTH;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_HOLD
    } fir32_state_t;

    typedef struct packed {
        logic             clear_acc;
        logic             shift_in;
        logic             load_coef;
        logic             mul_en;
        logic [TAP_W-1:0] tap;
        logic             load_out;
    } fir32_cmd_t;

    typedef struct packed {
        logic out_free;
    } fir32_status_t;

endpackage

FILE: rtl/fir32_in_if.sv
// Input channel of the FIR filter: operation, tap index and value words.
`timescale 1ns / 1ps

interface fir32_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic [fir32_pkg::INDEX_W-1:0]         tap_index;
    logic signed [fir32_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output operation, output tap_index, output value,
                    input ready);
    modport sink (input valid, input operation, input tap_index, input value,
                  output ready);
endinterface

FILE: rtl/fir32_out_if.sv
// Output channel of the FIR filter: one filtered sum per word.
`timescale 1ns / 1ps

interface fir32_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fir32_pkg::SUM_W-1:0]  filtered_sum;

    modport source (output valid, output filtered_sum, input ready);
    modport sink (input valid, input filtered_sum, output ready);
endinterface

FILE: rtl/fir32_ctrl.sv
// Controller state machine of the FIR filter: sequences the tap-by-tap accumulation.
`timescale 1ns / 1ps

module fir32_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_operation,
    output logic                     in_ready,
    input  fir32_pkg::fir32_status_t status,
    output fir32_pkg::fir32_cmd_t    cmd
);

    fir32_pkg::fir32_state_t          state_reg;
    fir32_pkg::fir32_state_t          state_next;
    logic [fir32_pkg::TAP_W-1:0]      cnt_reg;
    logic [fir32_pkg::TAP_W-1:0]      cnt_next;
    logic                             in_accept;
    logic                             last_tap;

    assign in_ready  = (state_reg == fir32_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign last_tap  = (cnt_reg == fir32_pkg::TAP_W'(fir32_pkg::TAPS - 1));

    // Next state and tap counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            fir32_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_accept && (in_operation == fir32_pkg::OP_FILTER))
                begin
                    state_next = fir32_pkg::ST_MAC;
                end
            end
            fir32_pkg::ST_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last_tap)
                begin
                    state_next = fir32_pkg::ST_DRAIN;
                end
            end
            fir32_pkg::ST_DRAIN:
            begin
                state_next = fir32_pkg::ST_HOLD;
            end
            fir32_pkg::ST_HOLD:
            begin
                if (status.out_free)
                begin
                    state_next = fir32_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fir32_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.tap       = cnt_reg;
        unique case (state_reg)
            fir32_pkg::ST_IDLE:
            begin
                cmd.load_coef = in_accept && (in_operation == fir32_pkg::OP_LOAD);
                cmd.shift_in  = in_accept && (in_operation == fir32_pkg::OP_FILTER);
                cmd.clear_acc = in_accept && (in_operation == fir32_pkg::OP_FILTER);
            end
            fir32_pkg::ST_MAC:
            begin
                cmd.mul_en = 1'b1;
            end
            fir32_pkg::ST_DRAIN:
            begin
                cmd.mul_en = 1'b0;
            end
            fir32_pkg::ST_HOLD:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd.mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fir32_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: rtl/fir32_datapath.sv
// Datapath of the FIR filter: delay line, coefficient store, multiply-accumulate, output register.
`timescale 1ns / 1ps

module fir32_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fir32_pkg::fir32_cmd_t                 cmd,
    output fir32_pkg::fir32_status_t              status,
    input  logic [fir32_pkg::INDEX_W-1:0]         tap_index,
    input  logic signed [fir32_pkg::VALUE_W-1:0]  value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fir32_pkg::SUM_W-1:0]    filtered_sum
);

    logic signed [fir32_pkg::SAMPLE_WIDTH-1:0] delay_reg [fir32_pkg::TAPS];
    logic signed [fir32_pkg::SAMPLE_WIDTH-1:0] coef_reg  [fir32_pkg::TAPS];
    logic signed [fir32_pkg::SAMPLE_WIDTH-1:0] sample;
    logic signed [fir32_pkg::PROD_W-1:0]       product_reg;
    logic                                      prod_valid_reg;
    logic signed [fir32_pkg::SUM_W-1:0]        acc_reg;
    logic signed [fir32_pkg::SUM_W-1:0]        acc_next;
    logic signed [fir32_pkg::SUM_W-1:0]        sum_out_reg;
    logic                                      out_valid_reg;
    logic                                      coef_in_range;
    logic [fir32_pkg::TAP_W-1:0]               coef_addr;

    assign sample        = value[fir32_pkg::SAMPLE_WIDTH-1:0];
    assign coef_in_range = (int'(tap_index) < fir32_pkg::TAPS);
    assign coef_addr     = fir32_pkg::TAP_W'(tap_index);

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign filtered_sum    = sum_out_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.clear_acc)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + fir32_pkg::SUM_W'(product_reg);
        end
    end

    // Delay line and coefficient store, both cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < fir32_pkg::TAPS; k++)
            begin
                delay_reg[k] <= '0;
                coef_reg[k]  <= '0;
            end
        end
        else
        begin
            if (cmd.shift_in)
            begin
                delay_reg[0] <= sample;
                for (int k = 1; k < fir32_pkg::TAPS; k++)
                begin
                    delay_reg[k] <= delay_reg[k-1];
                end
            end
            if (cmd.load_coef && coef_in_range)
            begin
                coef_reg[coef_addr] <= sample;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= cmd.mul_en;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= delay_reg[cmd.tap] * coef_reg[cmd.tap];
        acc_reg     <= acc_next;
        if (cmd.load_out)
        begin
            sum_out_reg <= acc_reg;
        end
    end

endmodule

FILE: rtl/fir_filter_32_tap_top.sv
// Top level of the 32-tap direct-form FIR filter.
`timescale 1ns / 1ps

// Direct-form FIR filter with 32 taps and Q1.15 samples and coefficients. Each input
// word either loads one coefficient (operation 1, at tap_index, no result word) or
// presents a sample (operation 0). A sample enters the head of the delay line, every
// older sample moves one tap along and the oldest drops out; the block then returns
// the exact sum of sample times coefficient over all taps as a 40-bit signed Q10.30
// word. Delay line and coefficients are cleared by reset. A coefficient load leaves
// the block ready again at once. A sample goes through these steps before the next
// word is accepted: accept and shift, one tap per cycle through the single shared
// 16 x 16 multiplier, add the last registered product, and move the sum into the
// output register. The output register holds a finished sum while the next word is
// taken; a sample that finishes while that register is still full waits until it is
// read.

module fir_filter_32_tap_top (
    input logic           clk,
    input logic           rst_n,
    fir32_in_if.sink      samples,
    fir32_out_if.source   sums
);

    fir32_pkg::fir32_cmd_t    cmd;
    fir32_pkg::fir32_status_t status;

    // Sequencer: accepts words and steps through the taps.
    fir32_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (samples.valid),
        .in_operation (samples.operation),
        .in_ready     (samples.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Storage, multiply-accumulate and the output register.
    fir32_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .tap_index    (samples.tap_index),
        .value        (samples.value),
        .out_valid    (sums.valid),
        .out_ready    (sums.ready),
        .filtered_sum (sums.filtered_sum)
    );

endmodule

FILE: rtl/fir32_checker.sv
// Port-level checker for the FIR filter top level, with its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fir32_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 in_operation,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [fir32_pkg::SUM_W-1:0]   filtered_sum
);

    logic sample_accept;
    logic load_accept;

    assign sample_accept = in_valid && in_ready && (in_operation == fir32_pkg::OP_FILTER);
    assign load_accept   = in_valid && in_ready && (in_operation == fir32_pkg::OP_LOAD);

    // A sample keeps the block busy for the cycle after it is taken.
    `ASSERT_NEXT(a_busy_after_sample, clk, rst_n, sample_accept, !in_ready)
    // A coefficient load leaves the block ready for the next word.
    `ASSERT_NEXT(a_ready_after_load, clk, rst_n, load_accept, in_ready)
    // A new result only appears while the block was busy with a sample.
    `ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(!in_ready))
    // A waiting result stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(filtered_sum))

endmodule

bind fir_filter_32_tap_top fir32_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .in_operation (samples.operation),
    .out_valid    (sums.valid),
    .out_ready    (sums.ready),
    .filtered_sum (sums.filtered_sum)
);
